### src/cfst_pkg.sv
// Types and constants shared by the CAN frame statistics table.
`timescale 1ns / 1ps
`default_nettype none
package cfst_pkg;

  // Operation codes
  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // Register indexes
  localparam logic REG_DIAG_LOW  = 1'b0;
  localparam logic REG_DIAG_HIGH = 1'b1;

  // Register reset values
  localparam logic [10:0] DIAG_LOW_RST  = 11'h7e8;
  localparam logic [10:0] DIAG_HIGH_RST = 11'h7ef;

  // Number of key bits from the data field used for diagnostic identifiers
  localparam int DIAG_KEY_W = 24;

  typedef struct packed {
    logic        operation;
    logic [28:0] frame_id;
    logic        frame_extended;
    logic        frame_remote;
    logic [3:0]  frame_length;
    logic [31:0] frame_data_low;
    logic [31:0] frame_data_high;
    logic [5:0]  read_index;
  } in_t;

  typedef struct packed {
    logic        entry_valid;
    logic [5:0]  entry_index;
    logic [28:0] entry_id;
    logic        entry_extended;
    logic        entry_remote;
    logic [3:0]  entry_length;
    logic [31:0] entry_data_low;
    logic [31:0] entry_data_high;
    logic [31:0] entry_count;
    logic [6:0]  table_fill;
    logic        frame_dropped;
  } out_t;

  // Token travelling down the row of cells
  typedef struct packed {
    logic done;    // a cell has already handled this transaction
    logic append;  // the handling cell took a new entry
    logic diag;    // identifier lies in the diagnostic range
    in_t  req;
    out_t res;
  } tok_t;

endpackage
`default_nettype wire

### src/cfst_cell.sv
// One table entry: stored fields plus a token stage passed to the next cell.
`timescale 1ns / 1ps
`default_nettype none
module cfst_cell #(
  parameter int TABLE_DEPTH = 64,
  parameter int INDEX       = 0
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic [$clog2(TABLE_DEPTH + 1) - 1:0] fill,
  input  wire logic                                 tok_in_active,
  input  wire cfst_pkg::tok_t                       tok_in,
  output logic                                      tok_out_active,
  output cfst_pkg::tok_t                            tok_out
);
  import cfst_pkg::*;

  localparam int FILL_W = $clog2(TABLE_DEPTH + 1);
  localparam int CW     = (FILL_W > 6) ? FILL_W : 6;

  logic [28:0]   id_r,    id_nxt;
  logic          ext_r,   ext_nxt;
  logic          rtr_r,   rtr_nxt;
  logic [3:0]    len_r,   len_nxt;
  logic [63:0]   data_r,  data_nxt;
  logic [31:0]   count_r, count_nxt;
  logic          active_r;
  tok_t          tok_r,   tok_nxt;

  logic          in_use;
  logic          at_end;
  logic          pending;
  logic [63:0]   data_in;
  logic          hit;
  logic          add;
  logic          rd;

  // Position of this cell against the current fill
  assign in_use  = CW'(INDEX) < CW'(fill);
  assign at_end  = CW'(INDEX) == CW'(fill);
  assign pending = tok_in_active && !tok_in.done;
  assign data_in = {tok_in.req.frame_data_high, tok_in.req.frame_data_low};

  // Match, append and read decisions
  always_comb begin
    hit = pending && (tok_in.req.operation == OP_FRAME) && in_use &&
          (id_r == tok_in.req.frame_id) &&
          (!tok_in.diag ||
           (data_r[DIAG_KEY_W-1:0] == data_in[DIAG_KEY_W-1:0]));
    add = pending && (tok_in.req.operation == OP_FRAME) && at_end;
    rd  = pending && (tok_in.req.operation == OP_READ) && in_use &&
          (CW'(INDEX) == CW'(tok_in.req.read_index));
  end

  // Entry update
  always_comb begin
    id_nxt    = id_r;
    ext_nxt   = ext_r;
    rtr_nxt   = rtr_r;
    len_nxt   = len_r;
    data_nxt  = data_r;
    count_nxt = count_r;
    if (hit) begin
      len_nxt   = tok_in.req.frame_length;
      data_nxt  = data_in;
      count_nxt = count_r + 32'd1;
    end else if (add) begin
      id_nxt    = tok_in.req.frame_id;
      ext_nxt   = tok_in.req.frame_extended;
      rtr_nxt   = tok_in.req.frame_remote;
      len_nxt   = tok_in.req.frame_length;
      data_nxt  = data_in;
      count_nxt = 32'd1;
    end
  end

  // Token update: the handling cell loads its entry into the result
  always_comb begin
    tok_nxt = tok_in;
    if (hit || add || rd) begin
      tok_nxt.done                = 1'b1;
      tok_nxt.append              = add;
      tok_nxt.res.entry_valid     = 1'b1;
      tok_nxt.res.entry_index     = 6'(INDEX);
      tok_nxt.res.entry_id        = id_nxt;
      tok_nxt.res.entry_extended  = ext_nxt;
      tok_nxt.res.entry_remote    = rtr_nxt;
      tok_nxt.res.entry_length    = len_nxt;
      tok_nxt.res.entry_data_low  = data_nxt[31:0];
      tok_nxt.res.entry_data_high = data_nxt[63:32];
      tok_nxt.res.entry_count     = count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    id_r    <= id_nxt;
    ext_r   <= ext_nxt;
    rtr_r   <= rtr_nxt;
    len_r   <= len_nxt;
    data_r  <= data_nxt;
    count_r <= count_nxt;
    tok_r   <= tok_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else begin
      active_r <= tok_in_active;
    end
  end

  assign tok_out_active = active_r;
  assign tok_out        = tok_r;

endmodule
`default_nettype wire

### src/can_frame_statistics_table.sv
// Top level of the CAN frame statistics table: control, registers and cell row.
//
// Usage:
//   An item is taken at a rising edge with start high and busy low. It is
//   either a received frame (matched against the table, then updated,
//   appended or dropped) or a read of one entry by index.
//   Each item gives one result on out_item, shown for one cycle with
//   out_strobe high. The receiver cannot stall; results are not held.
//   The item travels as a token down a row of TABLE_DEPTH cells, one cell
//   per cycle, each cell holding one entry; the result is registered after
//   the last cell. busy drops in the cycle the result is shown, so a new
//   item can be taken then; no new item is taken while one is in the row.
//   cfg_we writes diag_id_low (index 0) or diag_id_high (index 1) at once;
//   write only while busy is low.
//   Reset (rst_n low, synchronous) empties the table, clears busy and loads
//   the register defaults. Entry contents are not cleared; entries beyond
//   the fill are never used.
`timescale 1ns / 1ps
`default_nettype none
module can_frame_statistics_table #(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  output logic                busy,
  input  wire cfst_pkg::in_t  in_item,
  output logic                out_strobe,
  output cfst_pkg::out_t      out_item,
  input  wire logic           cfg_we,
  input  wire logic           cfg_index,
  input  wire logic [10:0]    cfg_wdata
);
  import cfst_pkg::*;

  localparam int FILL_W = $clog2(TABLE_DEPTH + 1);

  logic [10:0]       diag_low_r;
  logic [10:0]       diag_high_r;
  logic              busy_r;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              out_strobe_r;
  out_t              out_item_r, out_item_nxt;
  logic              accept;
  tok_t              tok_first;
  logic              act_chain [TABLE_DEPTH + 1];
  tok_t              tok_chain [TABLE_DEPTH + 1];
  logic              act_end;
  tok_t              tok_end;

  assign accept = start && !busy_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      diag_low_r  <= DIAG_LOW_RST;
      diag_high_r <= DIAG_HIGH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DIAG_LOW:  diag_low_r  <= cfg_wdata;
        REG_DIAG_HIGH: diag_high_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Token entering the row
  always_comb begin
    tok_first        = '0;
    tok_first.req    = in_item;
    tok_first.diag   = (in_item.frame_id >= 29'(diag_low_r)) &&
                       (in_item.frame_id <= 29'(diag_high_r));
  end

  assign act_chain[0] = accept;
  assign tok_chain[0] = tok_first;

  // Row of entry cells
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    cfst_cell #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .INDEX       (i)
    ) u_cell (
      .clk            (clk),
      .rst_n          (rst_n),
      .fill           (fill_r),
      .tok_in_active  (act_chain[i]),
      .tok_in         (tok_chain[i]),
      .tok_out_active (act_chain[i+1]),
      .tok_out        (tok_chain[i+1])
    );
  end

  assign act_end = act_chain[TABLE_DEPTH];
  assign tok_end = tok_chain[TABLE_DEPTH];

  // Fill count and result
  always_comb begin
    fill_nxt = fill_r;
    if (act_end && tok_end.done && tok_end.append) begin
      fill_nxt = fill_r + FILL_W'(1);
    end
    out_item_nxt               = tok_end.res;
    out_item_nxt.table_fill    = 7'(fill_nxt);
    out_item_nxt.frame_dropped = (tok_end.req.operation == OP_FRAME) && !tok_end.done;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      fill_r       <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      if (accept) begin
        busy_r <= 1'b1;
      end else if (act_end) begin
        busy_r <= 1'b0;
      end
      fill_r       <= fill_nxt;
      out_strobe_r <= act_end;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (act_end) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign busy       = busy_r;
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule
`default_nettype wire

### verif/tb_can_frame_statistics_table.sv
// Self-checking testbench for the CAN frame statistics table.
`timescale 1ns / 1ps
module tb_can_frame_statistics_table;
  import cfst_pkg::*;

  localparam int ENTRIES        = 64;
  localparam int RESULT_LATENCY = ENTRIES + 6;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_GAP        = 140;

  // Predicts each result from its own copy of the table and registers, and
  // checks results in order against what it predicted.
  class frame_stats_tracker;
    logic [28:0] ids       [ENTRIES];
    logic        ext_flags [ENTRIES];
    logic        rtr_flags [ENTRIES];
    logic [3:0]  lengths   [ENTRIES];
    logic [31:0] data_low  [ENTRIES];
    logic [31:0] data_high [ENTRIES];
    logic [31:0] counts    [ENTRIES];
    int unsigned fill;
    logic [10:0] diag_low, diag_high;
    out_t        pending_entries[$];
    int unsigned mismatches, checked;
    int unsigned n_updated, n_appended, n_dropped, n_reads, n_reads_past;

    function new();
      fill      = 0;
      diag_low  = DIAG_LOW_RST;
      diag_high = DIAG_HIGH_RST;
    endfunction

    function void set_reg(logic idx, logic [10:0] val);
      if (idx == REG_DIAG_LOW) diag_low = val;
      else diag_high = val;
    endfunction

    function out_t entry_result(int k);
      out_t r;
      r                 = '0;
      r.entry_valid     = 1'b1;
      r.entry_index     = k[5:0];
      r.entry_id        = ids[k];
      r.entry_extended  = ext_flags[k];
      r.entry_remote    = rtr_flags[k];
      r.entry_length    = lengths[k];
      r.entry_data_low  = data_low[k];
      r.entry_data_high = data_high[k];
      r.entry_count     = counts[k];
      return r;
    endfunction

    // Work out the result of one accepted transaction and queue it
    function void note_item(in_t it);
      out_t res;
      int   hit;
      int   k;
      bit   diag;
      res = '0;
      hit = -1;
      if (it.operation == OP_READ) begin
        if (it.read_index < fill) begin
          res = entry_result(it.read_index);
          n_reads++;
        end else begin
          n_reads_past++;
        end
      end else begin
        diag = (it.frame_id >= diag_low) && (it.frame_id <= diag_high);
        // first filled entry with the same identifier (and key, if diagnostic)
        for (k = 0; k < fill; k++) begin
          if (ids[k] == it.frame_id &&
              (!diag || data_low[k][23:0] == it.frame_data_low[23:0])) begin
            hit = k;
            break;
          end
        end
        if (hit >= 0) begin
          lengths[hit]   = it.frame_length;
          data_low[hit]  = it.frame_data_low;
          data_high[hit] = it.frame_data_high;
          counts[hit]    = counts[hit] + 32'd1;
          res = entry_result(hit);
          n_updated++;
        end else if (fill < ENTRIES) begin
          ids[fill]       = it.frame_id;
          ext_flags[fill] = it.frame_extended;
          rtr_flags[fill] = it.frame_remote;
          lengths[fill]   = it.frame_length;
          data_low[fill]  = it.frame_data_low;
          data_high[fill] = it.frame_data_high;
          counts[fill]    = 32'd1;
          res = entry_result(fill);
          fill++;
          n_appended++;
        end else begin
          res.frame_dropped = 1'b1;
          n_dropped++;
        end
      end
      res.table_fill = fill[6:0];
      pending_entries.push_back(res);
    endfunction

    // Compare one result against the oldest prediction
    function void check_result(out_t got);
      out_t  exp;
      string diffs;
      if (pending_entries.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result with nothing predicted: %p", got);
        return;
      end
      exp = pending_entries.pop_front();
      checked++;
      diffs = "";
      if (got.entry_valid     !== exp.entry_valid)     diffs = {diffs, " entry_valid"};
      if (got.entry_index     !== exp.entry_index)     diffs = {diffs, " entry_index"};
      if (got.entry_id        !== exp.entry_id)        diffs = {diffs, " entry_id"};
      if (got.entry_extended  !== exp.entry_extended)  diffs = {diffs, " entry_extended"};
      if (got.entry_remote    !== exp.entry_remote)    diffs = {diffs, " entry_remote"};
      if (got.entry_length    !== exp.entry_length)    diffs = {diffs, " entry_length"};
      if (got.entry_data_low  !== exp.entry_data_low)  diffs = {diffs, " entry_data_low"};
      if (got.entry_data_high !== exp.entry_data_high) diffs = {diffs, " entry_data_high"};
      if (got.entry_count     !== exp.entry_count)     diffs = {diffs, " entry_count"};
      if (got.table_fill      !== exp.table_fill)      diffs = {diffs, " table_fill"};
      if (got.frame_dropped   !== exp.frame_dropped)   diffs = {diffs, " frame_dropped"};
      if (diffs != "") begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result %0d differs in:%s", checked, diffs);
          $display("  expected %p", exp);
          $display("  actual   %p", got);
        end
      end
    endfunction
  endclass

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        start     = 1'b0;
  logic        busy;
  in_t         in_item   = '0;
  logic        out_strobe;
  out_t        out_item;
  logic        cfg_we    = 1'b0;
  logic        cfg_index = 1'b0;
  logic [10:0] cfg_wdata = '0;

  frame_stats_tracker tracker = new();
  int unsigned        stall_cycles = 0;
  bit                 idling_on = 1'b1;
  logic [28:0]        known_ids[$];
  logic [23:0]        diag_keys[4];

  can_frame_statistics_table #(.TABLE_DEPTH(ENTRIES)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Check results, note accepted transactions, watch for a hang
  always @(posedge clk) begin : monitor
    bit progress;
    progress = 1'b0;
    if (out_strobe === 1'b1) begin
      tracker.check_result(out_item);
      progress = 1'b1;
    end
    if (start === 1'b1 && busy === 1'b0) begin
      tracker.note_item(in_item);
      progress = 1'b1;
    end
    stall_cycles = progress ? 0 : stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("can_frame_statistics_table: mismatch");
      $finish;
    end
  end

  // Hold start until the block takes the transaction; idle now and then first
  task automatic send_item(input in_t it);
    int unsigned gap;
    gap = 0;
    if (idling_on && $urandom_range(99) < 18) gap = $urandom_range(MAX_GAP, 1);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // Stop sending and wait until the block is idle and every result is in
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (busy !== 1'b0 || tracker.pending_entries.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [10:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    tracker.set_reg(idx, val);
  endtask

  task automatic set_diag_range(input logic [10:0] lo, input logic [10:0] hi);
    settle();
    write_reg(REG_DIAG_LOW, lo);
    write_reg(REG_DIAG_HIGH, hi);
  endtask

  function automatic in_t frame(input logic [28:0] id, input logic ext, input logic rtr,
                                input logic [3:0] len, input logic [31:0] dlo,
                                input logic [31:0] dhi);
    in_t it;
    it                 = '0;
    it.operation       = OP_FRAME;
    it.frame_id        = id;
    it.frame_extended  = ext;
    it.frame_remote    = rtr;
    it.frame_length    = len;
    it.frame_data_low  = dlo;
    it.frame_data_high = dhi;
    it.read_index      = 6'($urandom);
    return it;
  endfunction

  function automatic in_t read_req(input logic [5:0] idx);
    in_t it;
    it            = '0;
    it.operation  = OP_READ;
    it.frame_id   = 29'($urandom);
    it.read_index = idx;
    return it;
  endfunction

  // Mostly frames on identifiers already seen, so entries get hit again
  function automatic in_t random_transaction();
    in_t         it;
    int unsigned pick;
    it.operation       = OP_FRAME;
    it.frame_id        = 29'($urandom);
    it.frame_extended  = 1'($urandom);
    it.frame_remote    = 1'($urandom);
    it.frame_length    = ($urandom_range(4) == 0) ? 4'($urandom_range(15, 9))
                                                  : 4'($urandom_range(8));
    it.frame_data_low  = $urandom;
    it.frame_data_high = $urandom;
    it.read_index      = 6'($urandom);
    pick = $urandom_range(99);
    if (pick < 20) begin
      it.operation = OP_READ;
    end else if (pick < 70 && known_ids.size() != 0) begin
      it.frame_id = known_ids[$urandom_range(known_ids.size() - 1)];
      if ($urandom_range(9) < 7) it.frame_data_low[23:0] = diag_keys[$urandom_range(3)];
    end else begin
      case ($urandom_range(3))
        0: it.frame_id = 29'($urandom_range(2047));
        1: it.frame_id = 29'($urandom_range(2047, 2016));
        default: ;
      endcase
      if ($urandom_range(1) == 0) it.frame_data_low[23:0] = diag_keys[$urandom_range(3)];
      if (known_ids.size() < 96) known_ids.push_back(it.frame_id);
    end
    return it;
  endfunction

  task automatic run_random(input int n);
    repeat (n) send_item(random_transaction());
  endtask

  // Stimulus
  initial begin
    foreach (diag_keys[i]) diag_keys[i] = 24'($urandom);
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes, matching rules and reads around the fill
    send_item(frame(29'h0, 1'b0, 1'b0, 4'd0, 32'h0, 32'h0));
    send_item(frame(29'h1fffffff, 1'b1, 1'b1, 4'd15, 32'hffffffff, 32'hffffffff));
    send_item(frame(29'h0, 1'b1, 1'b1, 4'd8, 32'h12345678, 32'h9abcdef0));
    send_item(frame(29'h7e8, 1'b0, 1'b0, 4'd8, 32'haa000001, 32'h0));
    send_item(frame(29'h7e8, 1'b0, 1'b0, 4'd3, 32'h55000001, 32'h0000ffff));
    send_item(frame(29'h7e8, 1'b0, 1'b0, 4'd8, 32'h00000002, 32'h0));
    send_item(frame(29'h7ef, 1'b0, 1'b0, 4'd2, 32'h00030201, 32'h0));
    send_item(frame(29'h7ef, 1'b0, 1'b1, 4'd2, 32'h00040201, 32'h0));
    send_item(frame(29'h7e7, 1'b0, 1'b0, 4'd1, 32'h00000001, 32'h0));
    send_item(frame(29'h7e7, 1'b0, 1'b0, 4'd1, 32'h00000002, 32'h0));
    send_item(frame(29'h7f0, 1'b0, 1'b0, 4'd4, 32'h00000001, 32'h0));
    send_item(frame(29'h7f0, 1'b1, 1'b0, 4'd4, 32'h00000007, 32'h0));
    // extended identifier inside the diagnostic range, then the same with ext clear
    send_item(frame(29'h7e8, 1'b1, 1'b0, 4'd8, 32'h00000009, 32'h0));
    send_item(frame(29'h7e8, 1'b0, 1'b0, 4'd8, 32'h00000009, 32'h1));
    send_item(frame(29'h10000000, 1'b0, 1'b0, 4'd9, 32'hdeadbeef, 32'h01020304));
    send_item(read_req(6'd0));
    send_item(read_req(6'd2));
    send_item(read_req(6'd9));
    send_item(read_req(6'd10));
    send_item(read_req(6'd63));
    known_ids = '{29'h0, 29'h7e8, 29'h7ef, 29'h7e7, 29'h7f0};

    // default range until the table fills
    run_random(200);
    // every standard identifier diagnostic, no idling at all
    set_diag_range(11'd0, 11'd2047);
    idling_on = 1'b0;
    run_random(100);
    idling_on = 1'b1;
    // empty range: first of several same-identifier entries wins
    set_diag_range(11'd2047, 11'd0);
    run_random(80);
    // single-identifier range
    set_diag_range(11'h7e8, 11'h7e8);
    run_random(60);
    set_diag_range(11'($urandom), 11'($urandom));
    run_random(60);

    settle();
    repeat (RESULT_LATENCY) @(posedge clk);
    $display("covered %0d results: %0d entry updates, %0d appends, %0d dropped frames",
             tracker.checked, tracker.n_updated, tracker.n_appended, tracker.n_dropped);
    $display("  %0d reads within the fill, %0d past it, over five diagnostic ranges",
             tracker.n_reads, tracker.n_reads_past);
    if (tracker.mismatches == 0 && tracker.pending_entries.size() == 0) begin
      $display("can_frame_statistics_table: match");
    end else begin
      $display("%0d mismatching results, %0d still outstanding",
               tracker.mismatches, tracker.pending_entries.size());
      $display("can_frame_statistics_table: mismatch");
    end
    $finish;
  end

endmodule
